@@ rtl/core/mvm_pkg.sv @@
// Shared types and constants for the matrix-vector multiply block.
`timescale 1ns / 1ps

package mvm_pkg;

  // Vector store depth and derived index widths
  localparam int MAX_COLS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CNT_W    = COL_W + 1;

  // Field widths fixed by the interface
  localparam int DATA_W    = 64;
  localparam int ROW_W     = 16;
  localparam int NCOLS_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // Input operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b1;

  // Which 32x32 partial product the shared multiplier forms
  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } mul_sel_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic     mul_en;    // capture a partial product
    mul_sel_t sel;       // which halves to multiply
    logic     add_ll;    // add the low x low product into the accumulator
    logic     cap_cross; // hold the first cross product
    logic     add_cross; // fold both cross products into the upper half
    logic     clear;     // zero the accumulator
  } mac_ctrl_t;

endpackage

@@ rtl/core/mvm_in_if.sv @@
// Input channel: operation code and element value with valid/ready.
`timescale 1ns / 1ps

interface mvm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [mvm_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ rtl/core/mvm_out_if.sv @@
// Result channel: row sum, row index and last-row flag with valid/ready.
`timescale 1ns / 1ps

interface mvm_out_if;
  logic                       valid;
  logic                       ready;
  logic [mvm_pkg::DATA_W-1:0] row_sum;
  logic [mvm_pkg::ROW_W-1:0]  row_index;
  logic                       last_row;

  modport source (output valid, output row_sum, output row_index, output last_row,
                  input ready);
  modport sink   (input valid, input row_sum, input row_index, input last_row,
                  output ready);
endinterface

@@ rtl/core/mvm_mac.sv @@
// Multiply-accumulate unit: 64x64 low-half product from one shared 32x32 multiplier.
`timescale 1ns / 1ps

module mvm_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mvm_pkg::mac_ctrl_t         ctrl,
  input  logic [mvm_pkg::DATA_W-1:0] a_i,
  input  logic [mvm_pkg::DATA_W-1:0] b_i,
  output logic [mvm_pkg::DATA_W-1:0] sum_o
);

  localparam int HALF_W = mvm_pkg::DATA_W / 2;

  logic [HALF_W-1:0]          mul_a;
  logic [HALF_W-1:0]          mul_b;
  logic [mvm_pkg::DATA_W-1:0] prod_w;
  logic [mvm_pkg::DATA_W-1:0] prod_r;
  logic [HALF_W-1:0]          cross_r;
  logic [mvm_pkg::DATA_W-1:0] acc_r;
  logic [mvm_pkg::DATA_W-1:0] acc_nxt;
  logic [HALF_W-1:0]          hi_sum;

  // Operand select for the shared multiplier
  always_comb begin
    case (ctrl.sel)
      mvm_pkg::MUL_LL: begin
        mul_a = a_i[HALF_W-1:0];
        mul_b = b_i[HALF_W-1:0];
      end
      mvm_pkg::MUL_LH: begin
        mul_a = a_i[HALF_W-1:0];
        mul_b = b_i[mvm_pkg::DATA_W-1:HALF_W];
      end
      mvm_pkg::MUL_HL: begin
        mul_a = a_i[mvm_pkg::DATA_W-1:HALF_W];
        mul_b = b_i[HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // Partial product registers; only the low half of a cross product matters
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_w;
    end
    if (ctrl.cap_cross) begin
      cross_r <= prod_r[HALF_W-1:0];
    end
  end

  // Upper half picks up both cross products, modulo 2^64
  assign hi_sum = acc_r[mvm_pkg::DATA_W-1:HALF_W] + cross_r + prod_r[HALF_W-1:0];
  assign sum_o  = {hi_sum, acc_r[HALF_W-1:0]};

  // Accumulator update
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.add_ll) begin
      acc_nxt = acc_r + prod_r;
    end else if (ctrl.add_cross) begin
      acc_nxt = sum_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // The low x low product must be folded in before the cross terms
  a_ll_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.add_ll |-> $past(ctrl.mul_en) && ($past(ctrl.sel) == mvm_pkg::MUL_LL))
    else $error("accumulate of low product without a fresh low x low product");

  a_cross_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.add_cross |-> $past(ctrl.cap_cross))
    else $error("cross terms folded before the first cross product was held");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.add_ll, ctrl.add_cross, ctrl.cap_cross}))
    else $error("conflicting accumulator controls");

endmodule

@@ rtl/core/matrix_vector_multiply.sv @@
// Top level: dense integer matrix-vector multiply with an on-chip vector store.
//
// Input transactions (in_ch) carry an operation and a signed 64-bit value.
// A load (operation 0) writes the next vector element and returns the matrix
// position to row 0, column 0; it gives no result.
// A matrix element (operation 1) is multiplied by the vector entry of its
// column and added to the row sum. The IDLE state accepts it and reads the
// vector memory, the LL, LH and HL states form the partial products on the
// shared 32x32 multiplier, and FIN folds the cross terms and updates the position.
// After the last column of a row a result transaction (row sum, row index,
// last-row flag) is registered onto out_ch; sums wrap modulo 2^64.
// The result sits in an output register: a stalled receiver does not block
// loads or earlier columns, and only the row-ending element waits in its
// final cycle until the register is free. Configuration (num_cols at index 0,
// num_rows at index 1) must be written while idle; the block itself does not
// enforce this. Reset clears the position, accumulator and registers to one
// column and one row; the vector store is not cleared and must be loaded first.
`timescale 1ns / 1ps

module matrix_vector_multiply (
  input  logic                          clk,
  input  logic                          rst_n,
  mvm_in_if.sink                        in_ch,
  mvm_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mvm_pkg::CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LL   = 5'b00010,
    ST_LH   = 5'b00100,
    ST_HL   = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [mvm_pkg::NCOLS_W-1:0] num_cols_r;
  logic [mvm_pkg::ROW_W-1:0]   num_rows_r;
  logic [mvm_pkg::COL_W-1:0]   load_ptr_r, load_ptr_nxt;
  logic [mvm_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [mvm_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [mvm_pkg::DATA_W-1:0]  value_r;

  logic [mvm_pkg::DATA_W-1:0]  vec_mem [mvm_pkg::MAX_COLS];
  logic [mvm_pkg::DATA_W-1:0]  vec_rdata_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [mvm_pkg::DATA_W-1:0]  out_row_sum_r;
  logic [mvm_pkg::ROW_W-1:0]   out_row_index_r;
  logic                        out_last_row_r;

  logic [31:0]                 ncols_w;
  logic [mvm_pkg::CNT_W-1:0]   cols_eff;
  logic [mvm_pkg::ROW_W:0]     rows_eff;
  logic [mvm_pkg::CNT_W-1:0]   ptr_inc;
  logic [mvm_pkg::CNT_W-1:0]   col_inc;
  logic [mvm_pkg::ROW_W:0]     row_inc;
  logic                        in_fire;
  logic                        is_load;
  logic                        row_end;
  logic                        last_w;
  logic                        slot_free;
  logic                        fin_go;
  logic                        res_fire;
  mvm_pkg::mac_ctrl_t          mac_ctrl;
  logic [mvm_pkg::DATA_W-1:0]  mac_sum;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= mvm_pkg::NCOLS_W'(1);
      num_rows_r <= mvm_pkg::ROW_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mvm_pkg::REG_NUM_COLS: num_cols_r <= cfg_wdata[mvm_pkg::NCOLS_W-1:0];
        mvm_pkg::REG_NUM_ROWS: num_rows_r <= cfg_wdata[mvm_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero means one, columns clamp at the store depth
  always_comb begin
    ncols_w = 32'(num_cols_r);
    if (ncols_w == 32'd0) begin
      ncols_w = 32'd1;
    end else if (ncols_w > 32'(mvm_pkg::MAX_COLS)) begin
      ncols_w = 32'(mvm_pkg::MAX_COLS);
    end
  end

  assign cols_eff = ncols_w[mvm_pkg::CNT_W-1:0];
  assign rows_eff = (num_rows_r == '0) ? (mvm_pkg::ROW_W+1)'(1) : {1'b0, num_rows_r};

  // Handshake and position arithmetic
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_load     = (in_ch.operation == mvm_pkg::OP_LOAD);
  assign ptr_inc     = {1'b0, load_ptr_r} + mvm_pkg::CNT_W'(1);
  assign col_inc     = {1'b0, col_r} + mvm_pkg::CNT_W'(1);
  assign row_inc     = {1'b0, row_r} + (mvm_pkg::ROW_W+1)'(1);
  assign row_end     = (col_inc >= cols_eff);
  assign last_w      = (row_inc >= rows_eff);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign fin_go      = (state_r == ST_FIN) && (!row_end || slot_free);
  assign res_fire    = fin_go && row_end;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && !is_load) begin
          state_nxt = ST_LL;
        end
      end
      ST_LL:   state_nxt = ST_LH;
      ST_LH:   state_nxt = ST_HL;
      ST_HL:   state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier schedule
  always_comb begin
    mac_ctrl           = '0;
    mac_ctrl.sel       = mvm_pkg::MUL_LL;
    mac_ctrl.mul_en    = (state_r == ST_LL) || (state_r == ST_LH) || (state_r == ST_HL);
    mac_ctrl.add_ll    = (state_r == ST_LH);
    mac_ctrl.cap_cross = (state_r == ST_HL);
    mac_ctrl.add_cross = fin_go && !row_end;
    mac_ctrl.clear     = (in_fire && is_load) || res_fire;
    if (state_r == ST_LH) begin
      mac_ctrl.sel = mvm_pkg::MUL_LH;
    end else if (state_r == ST_HL) begin
      mac_ctrl.sel = mvm_pkg::MUL_HL;
    end
  end

  // Position update
  always_comb begin
    load_ptr_nxt = load_ptr_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (in_fire && is_load) begin
      load_ptr_nxt = (ptr_inc >= cols_eff) ? '0 : ptr_inc[mvm_pkg::COL_W-1:0];
      col_nxt      = '0;
      row_nxt      = '0;
    end else if (fin_go) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = last_w ? '0 : row_inc[mvm_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_inc[mvm_pkg::COL_W-1:0];
      end
    end
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_ptr_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_ptr_r  <= load_ptr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire && !is_load) begin
      value_r <= in_ch.value;
    end
    if (res_fire) begin
      out_row_sum_r   <= mac_sum;
      out_row_index_r <= row_r;
      out_last_row_r  <= last_w;
    end
  end

  // Vector store: write on load, registered read on a matrix element
  always_ff @(posedge clk) begin
    if (in_fire && is_load) begin
      vec_mem[load_ptr_r] <= in_ch.value;
    end
    if (in_fire && !is_load) begin
      vec_rdata_r <= vec_mem[col_r];
    end
  end

  mvm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .a_i   (value_r),
    .b_i   (vec_rdata_r),
    .sum_o (mac_sum)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_sum   = out_row_sum_r;
  assign out_ch.row_index = out_row_index_r;
  assign out_ch.last_row  = out_last_row_r;

  // A matrix element always enters the multiply sequence
  a_mat_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_load) |=> (state_r == ST_LL))
    else $error("matrix transaction did not start the multiply sequence");

  // A load returns the position to the first row and column
  a_load_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_load) |=> (col_r == '0) && (row_r == '0))
    else $error("load did not reset the matrix position");

  // A result carries the row it ended and advances or wraps the row count
  a_res_row: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> out_valid_r && (out_row_index_r == $past(row_r))
                 && (out_last_row_r ? (row_r == '0) : (row_r == $past(row_r) + 1'b1)))
    else $error("result row index or row advance mismatch");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> (!out_valid_r || out_ch.ready))
    else $error("result written over an untaken result");

endmodule
